FILE: sv/compacting_slot_store_defines.svh
// ----------------------------------------------------------------------------
// Compacting slot store assertion macros
// Concurrent assertion helpers used by the slot store RTL.
// ----------------------------------------------------------------------------
`ifndef COMPACTING_SLOT_STORE_DEFINES_SVH
`define COMPACTING_SLOT_STORE_DEFINES_SVH

`ifndef SYNTHESIS
`define CSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("slot store assertion failed");
`define CSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("slot store assertion failed");
`else
`define CSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/css_pkg.sv
// ----------------------------------------------------------------------------
// Compacting slot store package
// Field widths, command and status codes and parameter defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package css_pkg;

	localparam int CMD_W       = 3;
	localparam int SLOT_IDX_W  = 5;
	localparam int DATA_W      = 64;
	localparam int STATUS_W    = 2;
	localparam int ENTRY_CNT_W = 6;

	localparam int SLOT_COUNT_DEF = 32;
	localparam int ENTRY_BITS_DEF = 64;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD    = 3'd0,
		CMD_GET    = 3'd1,
		CMD_REMOVE = 3'd2,
		CMD_UPDATE = 3'd3,
		CMD_CLEAR  = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK      = 2'd0,
		STS_FULL    = 2'd1,
		STS_INVALID = 2'd2
	} status_t;

endpackage

FILE: sv/css_if.sv
// ----------------------------------------------------------------------------
// Compacting slot store channels
// Command and response channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface css_cmd_if import css_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CMD_W-1:0]      cmd;
	logic [SLOT_IDX_W-1:0] slot_index;
	logic [DATA_W-1:0]     entry_data;

	modport source (output valid, cmd, slot_index, entry_data, input ready);
	modport sink (input valid, cmd, slot_index, entry_data, output ready);
endinterface

interface css_rsp_if import css_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [STATUS_W-1:0]    status;
	logic [DATA_W-1:0]      read_data;
	logic [ENTRY_CNT_W-1:0] entry_count;
	logic                   is_full;

	modport source (output valid, status, read_data, entry_count, is_full, input ready);
	modport sink (input valid, status, read_data, entry_count, is_full, output ready);
endinterface

FILE: sv/compacting_slot_store.sv
// ----------------------------------------------------------------------------
// Compacting slot store
// Ordered store of entry words with append, read, overwrite, remove and clear.
// ----------------------------------------------------------------------------
// Commands arrive on cmd_ch and each transaction yields exactly one response
// transaction on rsp_ch, carrying status, read data, entry count and full flag.
// The entries sit in a single-port-write, single-port-read memory; occupied
// slots always form the range from zero to the count, so entries past the
// count are never read and reset only needs to clear the count.
// Add, update, clear and rejected commands go from acceptance straight to the
// done state, a get passes through the read state for the registered memory
// read, and a remove passes through the shift state, where the entries after
// the removed slot move down one a cycle through the memory's one read and
// one write port.
// The block accepts one command at a time. A command may be accepted while
// the previous response still waits; it completes and then holds in its
// final state until the response register is free. Reset empties the store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "compacting_slot_store_defines.svh"

module compacting_slot_store import css_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF,
	parameter int ENTRY_BITS = ENTRY_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	css_cmd_if.sink   cmd_ch,
	css_rsp_if.source rsp_ch
);

	localparam int CNT_W = $clog2(SLOT_COUNT + 1);
	localparam int AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CMP_W = (CNT_W > SLOT_IDX_W) ? CNT_W : SLOT_IDX_W;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_READ  = 4'b0010,
		ST_SHIFT = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t                 st_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       src_q;
	logic                   pend_s1;
	logic [AW-1:0]          waddr_s1;
	status_t                res_status_q;
	logic [ENTRY_BITS-1:0]  res_data_q;
	logic                   out_valid_q;
	status_t                out_status_q;
	logic [ENTRY_BITS-1:0]  out_data_q;
	logic [ENTRY_CNT_W-1:0] out_count_q;
	logic                   out_full_q;

	logic [ENTRY_BITS-1:0]  mem_q [SLOT_COUNT];
	logic [ENTRY_BITS-1:0]  rdata_q;

	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [AW-1:0]          mem_raddr;
	logic [ENTRY_BITS-1:0]  mem_wdata;

	logic                   in_acc;
	logic                   full;
	logic                   slot_ok;
	logic                   issue;
	logic                   out_free;
	logic [CMP_W-1:0]       slot_ext;
	logic [AW-1:0]          slot_addr;
	logic [ENTRY_BITS-1:0]  in_data;
	cmd_t                   cmd;

	assign cmd_ch.ready = (st_q == ST_IDLE);
	assign in_acc       = cmd_ch.valid && cmd_ch.ready;
	assign cmd          = cmd_t'(cmd_ch.cmd);
	assign slot_ext     = CMP_W'(cmd_ch.slot_index);
	assign slot_addr    = slot_ext[AW-1:0];
	assign slot_ok      = slot_ext < CMP_W'(cnt_q);
	assign full         = (cnt_q == CNT_W'(SLOT_COUNT));
	assign in_data      = ENTRY_BITS'(cmd_ch.entry_data);
	assign out_free     = !out_valid_q || rsp_ch.ready;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q[AW-1:0];
		mem_wdata = in_data;
		mem_raddr = slot_addr;
		issue     = 1'b0;
		case (st_q)
			ST_IDLE: begin
				if (cmd_ch.valid) begin
					case (cmd)
						CMD_ADD: begin
							mem_we = !full;
						end
						CMD_UPDATE: begin
							mem_we    = slot_ok;
							mem_waddr = slot_addr;
						end
						default: begin
						end
					endcase
				end
			end
			ST_SHIFT: begin
				issue     = src_q < cnt_q;
				mem_raddr = src_q[AW-1:0];
				mem_we    = pend_s1;
				mem_waddr = waddr_s1;
				mem_wdata = rdata_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem_q[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			cnt_q       <= '0;
			src_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_s1 <= issue;
			if (out_valid_q && rsp_ch.ready && st_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						st_q <= ST_DONE;
						case (cmd)
							CMD_ADD: begin
								if (!full) begin
									cnt_q <= cnt_q + CNT_W'(1);
								end
							end
							CMD_GET: begin
								if (slot_ok) begin
									st_q <= ST_READ;
								end
							end
							CMD_REMOVE: begin
								if (slot_ok) begin
									src_q <= CNT_W'(slot_ext + CMP_W'(1));
									st_q  <= ST_SHIFT;
								end
							end
							CMD_CLEAR: begin
								cnt_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_READ: begin
					st_q <= ST_DONE;
				end
				ST_SHIFT: begin
					if (issue) begin
						src_q <= src_q + CNT_W'(1);
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
						st_q  <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						st_q        <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			waddr_s1 <= AW'(src_q - CNT_W'(1));
		end
		if (in_acc) begin
			res_data_q <= '0;
			case (cmd)
				CMD_ADD: begin
					res_status_q <= full ? STS_FULL : STS_OK;
				end
				CMD_GET, CMD_REMOVE, CMD_UPDATE: begin
					res_status_q <= slot_ok ? STS_OK : STS_INVALID;
				end
				default: begin
					res_status_q <= STS_OK;
				end
			endcase
		end
		if (st_q == ST_READ) begin
			res_data_q <= rdata_q;
		end
		if (st_q == ST_DONE && out_free) begin
			out_status_q <= res_status_q;
			out_data_q   <= res_data_q;
			out_count_q  <= ENTRY_CNT_W'(cnt_q);
			out_full_q   <= full;
		end
	end

	assign rsp_ch.valid       = out_valid_q;
	assign rsp_ch.status      = out_status_q;
	assign rsp_ch.read_data   = DATA_W'(out_data_q);
	assign rsp_ch.entry_count = out_count_q;
	assign rsp_ch.is_full     = out_full_q;

	`CSS_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(SLOT_COUNT))
	`CSS_ASSERT_IMP(a_shift_src, clk, arst_n, st_q == ST_SHIFT, src_q <= cnt_q && src_q != '0)
	`CSS_ASSERT_IMP(a_shift_wr, clk, arst_n, st_q == ST_SHIFT && pend_s1, CNT_W'(waddr_s1) < cnt_q)
	`CSS_ASSERT_NXT(a_clear_cnt, clk, arst_n, in_acc && cmd == CMD_CLEAR, cnt_q == '0)
	`CSS_ASSERT_NXT(a_done_out, clk, arst_n, st_q == ST_DONE && out_free, out_valid_q && st_q == ST_IDLE)

endmodule
